// ----- rtl/sob_pkg.sv -----
package sob_pkg;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int DIFF_W = 11;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int OP_W   = 16;
  localparam int MAG_W  = 8;

  // Square root steps, one result bit each
  localparam int SQRT_STEPS = MAG_W;

  // Saturation: any squared length at or above 255*255 maps to 255
  localparam logic [MAG_W-1:0] MAG_MAX   = 8'd255;
  localparam logic [SQ_W-1:0]  SAT_LIMIT = 22'(255 * 255);

  // Stream widths
  localparam int IN_TDATA_W  = 8 * PIX_W;
  localparam int OUT_TDATA_W = 32;

  // Signed Sobel sums
  typedef struct packed {
    logic signed [DIFF_W-1:0] row;
    logic signed [DIFF_W-1:0] col;
  } diff_t;

  // Squared terms
  typedef struct packed {
    logic [SQ_W-1:0] sq_row;
    logic [SQ_W-1:0] sq_col;
    diff_t           diff;
  } square_t;

  // Square root working state carried down the pipeline
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [OP_W-1:0] res;
    logic            sat;
    diff_t           diff;
  } root_stage_t;

endpackage

// ----- rtl/sob_diff.sv -----
module sob_diff (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [sob_pkg::IN_TDATA_W-1:0]        in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sob_pkg::diff_t                        out_diff
);

  logic [sob_pkg::PIX_W-1:0] ul, um, ur, ml, mr, dl, dm, dr;
  logic [sob_pkg::DIFF_W-2:0] top_sum, bot_sum, left_sum, right_sum;
  sob_pkg::diff_t diff_next;
  logic valid;
  sob_pkg::diff_t diff;

  // Unpack the eight neighbors
  assign ul = in_data[7:0];
  assign um = in_data[15:8];
  assign ur = in_data[23:16];
  assign ml = in_data[31:24];
  assign mr = in_data[39:32];
  assign dl = in_data[47:40];
  assign dm = in_data[55:48];
  assign dr = in_data[63:56];

  // Weighted 1,2,1 sums of rows and columns
  always_comb begin
    top_sum   = 10'(ul) + {1'b0, um, 1'b0} + 10'(ur);
    bot_sum   = 10'(dl) + {1'b0, dm, 1'b0} + 10'(dr);
    left_sum  = 10'(ul) + {1'b0, ml, 1'b0} + 10'(dl);
    right_sum = 10'(ur) + {1'b0, mr, 1'b0} + 10'(dr);
    diff_next.row = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});
    diff_next.col = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
  end

  assign in_ready = !valid || out_ready;

  // Hold valid with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      diff <= diff_next;
    end
  end

  assign out_valid = valid;
  assign out_diff  = diff;

endmodule

// ----- rtl/sob_square.sv -----
module sob_square (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sob_pkg::diff_t       in_diff,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sob_pkg::root_stage_t out_stage
);

  logic signed [sob_pkg::SQ_W-1:0] prod_row, prod_col;
  logic [sob_pkg::SQ_W-1:0] sum;
  logic sq_valid, sum_valid;
  logic sq_ready;
  sob_pkg::square_t sq;
  sob_pkg::root_stage_t stage;

  // Square both sums, one multiplier each
  assign prod_row = in_diff.row * in_diff.row;
  assign prod_col = in_diff.col * in_diff.col;

  assign sq_ready = !sum_valid || out_ready;
  assign in_ready = !sq_valid || sq_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (in_ready) begin
      sq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      sq.sq_row <= prod_row;
      sq.sq_col <= prod_col;
      sq.diff   <= in_diff;
    end
  end

  // Add the squares and flag saturation
  assign sum = sq.sq_row + sq.sq_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (sq_ready) begin
      sum_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sq_ready && sq_valid) begin
      stage.op   <= sum[sob_pkg::OP_W-1:0];
      stage.res  <= '0;
      stage.sat  <= (sum >= sob_pkg::SAT_LIMIT);
      stage.diff <= sq.diff;
    end
  end

  assign out_valid = sum_valid;
  assign out_stage = stage;

endmodule

// ----- rtl/sob_isqrt.sv -----
module sob_isqrt (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sob_pkg::root_stage_t in_stage,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sob_pkg::root_stage_t out_stage
);

  localparam int N = sob_pkg::SQRT_STEPS;

  logic [N-1:0] valid;
  logic [N-1:0] ready;
  sob_pkg::root_stage_t stage [N];

  // One result bit per stage, restoring square root
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [sob_pkg::OP_W-1:0] ONE = 16'(1 << (2 * (N - 1 - k)));
    logic prev_valid;
    sob_pkg::root_stage_t prev;
    sob_pkg::root_stage_t stage_next;
    logic [sob_pkg::OP_W:0] trial;

    if (k == 0) begin : g_first
      assign prev_valid = in_valid;
      assign prev       = in_stage;
    end else begin : g_rest
      assign prev_valid = valid[k-1];
      assign prev       = stage[k-1];
    end

    if (k == N - 1) begin : g_last
      assign ready[k] = !valid[k] || out_ready;
    end else begin : g_mid
      assign ready[k] = !valid[k] || ready[k+1];
    end

    always_comb begin
      trial      = {1'b0, prev.res} + {1'b0, ONE};
      stage_next = prev;
      if ({1'b0, prev.op} >= trial) begin
        stage_next.op  = prev.op - trial[sob_pkg::OP_W-1:0];
        stage_next.res = (prev.res >> 1) + ONE;
      end else begin
        stage_next.res = prev.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (ready[k]) begin
        valid[k] <= prev_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (ready[k] && prev_valid) begin
        stage[k] <= stage_next;
      end
    end
  end

  assign in_ready  = ready[0];
  assign out_valid = valid[N-1];
  assign out_stage = stage[N-1];

endmodule

// ----- rtl/sobel_gradient_3x3.sv -----
// Channel  Direction  tdata fields, lowest bit first
// s_axis   in         up_left, up_mid, up_right, mid_left, mid_right,
//                     down_left, down_mid, down_right (8 bits each)
// m_axis   out        magnitude (8), row_difference (11), column_difference (11),
//                     2 zero bits
//
// One window per cycle sustained while m_axis_tready stays high; the stages are
// one for the Sobel sums, one for the squares, one for their sum, and eight
// for the square root, one result bit each.
// Synchronous reset empties every stage; no other state is kept.
// Each stage holds its item while the next one is full and stalled, so a stall on m_axis
// fills empty stages before s_axis_tready drops.
module sobel_gradient_3x3 (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // up_left, up_mid, up_right, mid_left, mid_right, down_left, down_mid, down_right
  input  logic [sob_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // magnitude, row_difference, column_difference, zero fill
  output logic [sob_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic diff_valid, diff_ready;
  sob_pkg::diff_t diff;
  logic sum_valid, sum_ready;
  sob_pkg::root_stage_t sum_stage;
  sob_pkg::root_stage_t root;
  logic [sob_pkg::MAG_W-1:0] magnitude;
  logic [sob_pkg::DIFF_W-1:0] row_abs, col_abs;

  sob_diff u_diff (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (diff_valid),
    .out_ready (diff_ready),
    .out_diff  (diff)
  );

  sob_square u_square (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (diff_valid),
    .in_ready  (diff_ready),
    .in_diff   (diff),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .out_stage (sum_stage)
  );

  sob_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .in_stage  (sum_stage),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_stage (root)
  );

  // Clamp to full scale on saturation
  assign magnitude = root.sat ? sob_pkg::MAG_MAX : root.res[sob_pkg::MAG_W-1:0];

  assign m_axis_tdata = {2'b00, root.diff.col, root.diff.row, magnitude};

  assign row_abs = root.diff.row[sob_pkg::DIFF_W-1] ? 11'(-root.diff.row) : root.diff.row;
  assign col_abs = root.diff.col[sob_pkg::DIFF_W-1] ? 11'(-root.diff.col) : root.diff.col;

  // Pipeline is empty right after reset
  a_reset_empty: assert property (@(posedge clk) (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // An empty output stage frees the whole chain
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output stage");

  // Unsaturated length is never below either component
  a_mag_bound: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && magnitude != sob_pkg::MAG_MAX) |->
      (11'(magnitude) >= row_abs && 11'(magnitude) >= col_abs))
    else $error("magnitude below a component");

  // Zero length exactly when both Sobel sums are zero
  a_mag_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ((magnitude == '0) == (root.diff.row == '0 && root.diff.col == '0)))
    else $error("zero magnitude mismatch");

endmodule
